### hdl/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the slotted page manager.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned SLOT_BYTES       = 4;
  localparam int unsigned SLOT_LIMIT       = 1024;

  localparam int unsigned LEN_W  = 13;
  localparam int unsigned SIDX_W = 10;
  localparam int unsigned SCNT_W = 11;
  localparam int unsigned BOFF_W = 12;
  localparam int unsigned SUM_W  = 14;
  localparam int unsigned CMP_W  = 17;
  localparam int unsigned ENTRY_W = 2 * LEN_W;

  localparam logic [3:0] OP_INIT      = 4'd0;
  localparam logic [3:0] OP_INSERT    = 4'd1;
  localparam logic [3:0] OP_DELETE    = 4'd2;
  localparam logic [3:0] OP_OVERWRITE = 4'd3;
  localparam logic [3:0] OP_READ      = 4'd4;
  localparam logic [3:0] OP_SLOTINFO  = 4'd5;
  localparam logic [3:0] OP_SETLSN    = 4'd6;
  localparam logic [3:0] OP_GETLSN    = 4'd7;
  localparam logic [3:0] OP_SPACE     = 4'd8;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_INVAL    = 3'd1;
  localparam logic [2:0] STAT_NOSPACE  = 3'd2;
  localparam logic [2:0] STAT_NOTFOUND = 3'd3;
  localparam logic [2:0] STAT_CORRUPT  = 3'd4;

  localparam logic [0:0] REG_PAGE_SIZE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SLOT  = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_CLEAR = 4'b1000
  } spm_state_e;

  typedef struct packed {
    logic [63:0]       wide_value;
    logic [7:0]        data_byte;
    logic [BOFF_W-1:0] byte_offset;
    logic [LEN_W-1:0]  tuple_length;
    logic [SIDX_W-1:0] slot_index;
  } spm_item_t;

  typedef struct packed {
    logic [4:0]        pad;
    logic [LEN_W-1:0]  free_bytes;
    logic [SCNT_W-1:0] slot_total;
    logic [63:0]       wide_result;
    logic              slot_live;
    logic [LEN_W-1:0]  slot_length;
    logic [7:0]        read_byte;
    logic [SIDX_W-1:0] slot_result;
    logic [2:0]        status;
  } spm_result_t;

endpackage

### hdl/slotted_page_manager.sv
// ----------------------------------------------------------------------------
// slotted_page_manager
// Slotted database page: slot directory RAM, tuple byte RAM, control.
// ----------------------------------------------------------------------------
// Each item passes through accept, slot directory read, then byte RAM
// read data and execution, which also loads the result register; a result
// that is not taken holds the block in execution. Init is followed by a
// clearing pass over every byte of the tuple RAM, during which no item
// is accepted; configuration writes are taken at any time.
module slotted_page_manager #(
  parameter int unsigned PAGE_BYTES   = spm_pkg::PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = spm_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // slot_index, tuple_length, byte_offset, data_byte, wide_value, zero pad
  input  logic [111:0] s_axis_tdata_i,
  // opcode
  input  logic [3:0]   s_axis_tuser_i,
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status, slot_result, read_byte, slot_length, slot_live, wide_result,
  // slot_total, free_bytes, zero pad
  output logic [127:0] m_axis_tdata_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import spm_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_BYTES);
  localparam logic [CMP_W-1:0] PAGE_L = CMP_W'(PAGE_BYTES);
  localparam logic [CMP_W-1:0] HDR_L  = CMP_W'(HEADER_BYTES);

  spm_state_e state_q, state_d;
  logic [LEN_W-1:0]  psize_q;
  logic [SCNT_W-1:0] se_q, se_d;
  logic [LEN_W-1:0]  fs_q, fs_d, fe_q, fe_d, ib_q, ib_d;
  logic              fail_q, fail_d;
  logic [63:0]       lsn_q, lsn_d;
  logic [AW-1:0]     clr_q;
  logic              out_valid_q;
  spm_result_t       out_q, res;

  logic [3:0]  op_q;
  spm_item_t   item_q, item_in;
  logic        last_q;
  logic        inr_q;

  logic in_fire, exec_fire, clear_start, size_ok;
  logic [ENTRY_W-1:0] sr_data, sw_data;
  logic [LEN_W-1:0]   rd_off, rd_len;
  logic               sw_we;
  logic [SIDX_W-1:0]  sw_addr, sr_addr;
  logic               bw_we;
  logic [SUM_W-1:0]   bw_sum, br_sum;
  logic [7:0]         br_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PAGE_SIZE) ? {19'd0, psize_q} : 32'd0;

  assign item_in         = spm_item_t'(s_axis_tdata_i[106:0]);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign exec_fire       = (state_q == ST_EXEC) && (!out_valid_q || m_axis_tready_i);
  assign size_ok = ({4'd0, psize_q} >= HDR_L) && ({4'd0, psize_q} <= PAGE_L);

  assign sr_addr = (s_axis_tuser_i == OP_INSERT) ? SIDX_W'(se_q - 11'd1)
                                                  : item_in.slot_index;
  assign {rd_off, rd_len} = sr_data;
  assign br_sum = {1'b0, rd_off} + {2'b0, item_q.byte_offset};

  spm_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_LIMIT)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (exec_fire && sw_we),
    .waddr_i (sw_addr),
    .wdata_i (sw_data),
    .re_i    (in_fire),
    .raddr_i (sr_addr),
    .rdata_o (sr_data)
  );

  spm_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_CLEAR) ||
              (exec_fire && bw_we && ({3'd0, bw_sum} < PAGE_L))),
    .waddr_i ((state_q == ST_CLEAR) ? clr_q : AW'(bw_sum)),
    .wdata_i ((state_q == ST_CLEAR) ? 8'd0 : item_q.data_byte),
    .re_i    (state_q == ST_SLOT),
    .raddr_i (AW'(br_sum)),
    .rdata_o (br_data)
  );

  always_comb begin
    logic [SUM_W-1:0]  fe14, fs14, room, need;
    logic [SCNT_W-1:0] se_n;
    logic [LEN_W-1:0]  len_chk, ib_n, base;
    logic              fail_n;
    fe14 = {1'b0, fe_q};
    fs14 = {1'b0, fs_q};
    room = fe14 - fs14;
    need = {1'b0, item_q.tuple_length} + SUM_W'(SLOT_BYTES);
    se_n = se_q;
    len_chk = rd_len;
    ib_n = ib_q;
    fail_n = fail_q;
    base = fe_q - item_q.tuple_length;
    res = '0;
    se_d = se_q;
    fs_d = fs_q;
    fe_d = fe_q;
    ib_d = ib_q;
    fail_d = fail_q;
    lsn_d = lsn_q;
    sw_we = 1'b0;
    sw_addr = item_q.slot_index;
    sw_data = '0;
    bw_we = 1'b0;
    bw_sum = '0;
    clear_start = 1'b0;
    if (!size_ok || op_q > OP_SPACE) begin
      res.status = STAT_INVAL;
    end else begin
      unique case (op_q)
        OP_INIT: begin
          se_d = '0;
          fs_d = LEN_W'(HEADER_BYTES);
          fe_d = psize_q;
          lsn_d = '0;
          ib_d = '0;
          fail_d = 1'b0;
          clear_start = 1'b1;
        end
        OP_INSERT: begin
          if (item_q.byte_offset == '0) begin
            if (fe_q < fs_q) begin
              res.status = STAT_CORRUPT;
              fail_n = 1'b1;
            end else if (se_q >= SCNT_W'(SLOT_LIMIT) || room < need) begin
              res.status = STAT_NOSPACE;
              fail_n = 1'b1;
            end else begin
              sw_we = 1'b1;
              sw_addr = se_q[SIDX_W-1:0];
              sw_data = {base, item_q.tuple_length};
              se_n = se_q + 11'd1;
              fs_d = LEN_W'(HEADER_BYTES + 32'(se_n) * SLOT_BYTES);
              fe_d = base;
              ib_n = base;
              fail_n = 1'b0;
              len_chk = item_q.tuple_length;
            end
          end else if (fail_q) begin
            res.status = STAT_NOSPACE;
          end
          if (!fail_n && se_n != '0) begin
            if ({1'b0, item_q.byte_offset} < len_chk) begin
              bw_we = 1'b1;
              bw_sum = {1'b0, ib_n} + {2'b0, item_q.byte_offset};
            end
            if (last_q) begin
              res.slot_result = SIDX_W'(se_n - 11'd1);
            end
          end
          se_d = se_n;
          ib_d = ib_n;
          fail_d = fail_n;
        end
        OP_DELETE, OP_OVERWRITE, OP_READ, OP_SLOTINFO: begin
          if ({1'b0, item_q.slot_index} >= se_q) begin
            res.status = STAT_INVAL;
          end else begin
            res.slot_length = rd_len;
            res.slot_live = (rd_len != '0);
            if (op_q == OP_SLOTINFO) begin
              res.status = STAT_OK;
            end else if (rd_len == '0) begin
              res.status = STAT_NOTFOUND;
            end else if (op_q == OP_DELETE) begin
              sw_we = 1'b1;
            end else if (op_q == OP_OVERWRITE && rd_len != item_q.tuple_length) begin
              res.status = STAT_INVAL;
            end else if (({1'b0, rd_off} + {1'b0, rd_len}) > {1'b0, psize_q}) begin
              res.status = STAT_CORRUPT;
            end else if (op_q == OP_OVERWRITE) begin
              if ({1'b0, item_q.byte_offset} < rd_len) begin
                bw_we = 1'b1;
                bw_sum = {1'b0, rd_off} + {2'b0, item_q.byte_offset};
              end
            end else if ({1'b0, item_q.byte_offset} >= rd_len) begin
              res.status = STAT_INVAL;
            end else begin
              res.read_byte = inr_q ? br_data : 8'd0;
            end
          end
        end
        OP_SETLSN: lsn_d = item_q.wide_value;
        OP_GETLSN: res.wide_result = lsn_q;
        OP_SPACE: begin
          if (fe_q < fs_q) begin
            res.status = STAT_CORRUPT;
          end
        end
        default: res.status = STAT_INVAL;
      endcase
    end
    res.slot_total = se_d;
    res.free_bytes = (fe_d >= fs_d) ? fe_d - fs_d : '0;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SLOT;
      ST_SLOT:  state_d = ST_EXEC;
      ST_EXEC:  if (exec_fire) state_d = clear_start ? ST_CLEAR : ST_IDLE;
      ST_CLEAR: if (clr_q == AW'(PAGE_BYTES - 1)) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      psize_q <= 13'd4096;
      se_q <= '0;
      fs_q <= LEN_W'(HEADER_BYTES);
      fe_q <= 13'd4096;
      ib_q <= '0;
      fail_q <= 1'b0;
      lsn_q <= '0;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (psel && penable && pwrite && pready && paddr[2] == REG_PAGE_SIZE) begin
        psize_q <= pwdata[LEN_W-1:0];
      end
      if (exec_fire) begin
        se_q <= se_d;
        fs_q <= fs_d;
        fe_q <= fe_d;
        ib_q <= ib_d;
        fail_q <= fail_d;
        lsn_q <= lsn_d;
        clr_q <= '0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= s_axis_tuser_i;
      item_q <= item_in;
      last_q <= s_axis_tlast_i;
    end
    if (state_q == ST_SLOT) begin
      inr_q <= ({3'd0, br_sum} < PAGE_L);
    end
    if (exec_fire) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  a_slot_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    se_q <= SCNT_W'(SLOT_LIMIT))
    else $error("slot count above limit");

  a_free_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fs_q) == HEADER_BYTES + 32'(se_q) * SLOT_BYTES)
    else $error("free start out of step with slot count");

  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_q && (state_q == ST_IDLE || state_q == ST_CLEAR))
    else $error("executed item gave no result");

  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !(in_fire && $past(clr_q) != AW'(PAGE_BYTES - 1)))
    else $error("item accepted during clearing pass");

endmodule

### hdl/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram
// Simple dual-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module spm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
